@@ rtl/ffa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

	localparam int MaxSegmentsDefault = 32;
	localparam int AddrWidthDefault   = 16;
	localparam int CfgWidth           = 16;

	localparam logic [CfgWidth-1:0] ReservedSizeReset = 16'd1;
	localparam logic [CfgWidth-1:0] HeapLimitReset    = 16'd4096;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic CFG_RESERVED_SIZE = 1'b0;
	localparam logic CFG_HEAP_LIMIT    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SPACE   = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} alloc_status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_NXT, S_MERGE, S_DN_RD, S_DN_WR,
		S_UP_RD, S_UP_WR, S_SPLIT1, S_SPLIT2, S_APPEND, S_FIN
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NONE, DP_LOAD, DP_SCAN_RD, DP_SCAN_CHK, DP_NXT, DP_MERGE, DP_DN_RD,
		DP_DN_WR, DP_UP_RD, DP_UP_WR, DP_SPLIT1, DP_SPLIT2, DP_APPEND, DP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_free;
		logic scan_end;
		logic fit;
		logic rest_zero;
		logic full;
		logic match;
		logic next_exists;
		logic k_zero;
		logic dn_end;
		logic up_end;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/ffa_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for scan, shift and merge steps of one request.
// ---------------------------------------------------------------------------
module ffa_ctrl
	import ffa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (s_tvalid) state_d = S_SCAN_RD;
			S_SCAN_RD: begin
				if (status.scan_end) state_d = status.is_free ? S_FIN : S_APPEND;
				else state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (status.is_free) begin
					if (!status.match) state_d = S_SCAN_RD;
					else state_d = status.next_exists ? S_NXT : S_MERGE;
				end else begin
					if (!status.fit) state_d = S_SCAN_RD;
					else if (status.rest_zero || status.full) state_d = S_FIN;
					else state_d = S_UP_RD;
				end
			end
			S_NXT:      state_d = S_MERGE;
			S_MERGE:    state_d = status.k_zero ? S_FIN : S_DN_RD;
			S_DN_RD:    state_d = status.dn_end ? S_FIN : S_DN_WR;
			S_DN_WR:    state_d = S_DN_RD;
			S_UP_RD:    state_d = status.up_end ? S_SPLIT1 : S_UP_WR;
			S_UP_WR:    state_d = S_UP_RD;
			S_SPLIT1:   state_d = S_SPLIT2;
			S_SPLIT2:   state_d = S_FIN;
			S_APPEND:   state_d = S_FIN;
			S_FIN:      if (status.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd.op   = DP_NONE;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd.op = DP_LOAD;
			end
			S_SCAN_RD:  cmd.op = DP_SCAN_RD;
			S_SCAN_CHK: cmd.op = DP_SCAN_CHK;
			S_NXT:      cmd.op = DP_NXT;
			S_MERGE:    cmd.op = DP_MERGE;
			S_DN_RD:    cmd.op = DP_DN_RD;
			S_DN_WR:    cmd.op = DP_DN_WR;
			S_UP_RD:    cmd.op = DP_UP_RD;
			S_UP_WR:    cmd.op = DP_UP_WR;
			S_SPLIT1:   cmd.op = DP_SPLIT1;
			S_SPLIT2:   cmd.op = DP_SPLIT2;
			S_APPEND:   cmd.op = DP_APPEND;
			S_FIN:      if (status.out_free) cmd.op = DP_FIN;
			default:    cmd.op = DP_NONE;
		endcase
	end

endmodule

@@ rtl/ffa_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_dp
// Segment table memory, scan registers, config registers and output stage.
// ---------------------------------------------------------------------------
module ffa_dp
	import ffa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MaxSegmentsDefault,
	parameter int ADDR_WIDTH   = AddrWidthDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic                  in_cmd,
	input  logic [ADDR_WIDTH-1:0] in_size,
	input  logic [ADDR_WIDTH-1:0] in_where,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CfgWidth-1:0]   cfg_wdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_WIDTH-1:0] out_addr,
	output logic [1:0]            out_status
);

	localparam int AW  = ADDR_WIDTH;
	localparam int EN  = 2 * AW + 1;
	localparam int CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int IW  = $clog2(MAX_SEGMENTS);
	localparam int XW  = ((AW > CfgWidth) ? AW : CfgWidth) + 2;

	logic [EN-1:0] mem [MAX_SEGMENTS];
	logic [EN-1:0] rdata_s1;
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [EN-1:0] wr_data;

	logic [CfgWidth-1:0] reserved_q, limit_q;
	logic [CW-1:0]       cnt_q, idx_q, dst_q;
	logic [1:0]          k_q;
	logic                cmd_q;
	logic [AW-1:0]       size_q, where_q, start_q, rest_q;
	logic [AW-1:0]       prev_start_q, prev_len_q, cur_len_q, nxt_len_q;
	logic                prev_used_q, nxt_used_q;
	logic [XW-1:0]       end_q;
	logic [AW-1:0]       res_addr_q;
	alloc_status_t       res_st_q;
	logic                out_valid_q;
	logic [AW-1:0]       out_addr_q;
	alloc_status_t       out_st_q;

	logic [AW-1:0] r_start, r_len;
	logic          r_used;
	logic          prev_free, nxt_free;
	logic [1:0]    k_d;
	logic [CW-1:0] p_d;
	logic [AW-1:0] merge_len, merge_start;
	logic [XW-1:0] app_base, app_end;
	logic [CW:0]   dn_src;

	assign r_start = rdata_s1[2*AW:AW+1];
	assign r_len   = rdata_s1[AW:1];
	assign r_used  = rdata_s1[0];

	assign prev_free   = (idx_q != '0) && !prev_used_q;
	assign nxt_free    = !nxt_used_q;
	assign k_d         = {1'b0, prev_free} + {1'b0, nxt_free};
	assign p_d         = prev_free ? (idx_q - 1'b1) : idx_q;
	assign merge_start = prev_free ? prev_start_q : where_q;
	assign merge_len   = (prev_free ? prev_len_q : '0) + cur_len_q + (nxt_free ? nxt_len_q : '0);
	assign app_base    = (cnt_q == '0) ? XW'(reserved_q) : end_q;
	assign app_end     = app_base + XW'(size_q);
	assign dn_src      = {1'b0, dst_q} + (CW + 1)'(k_q);

	always_comb begin
		status.is_free     = cmd_q == CMD_FREE;
		status.scan_end    = idx_q == cnt_q;
		status.fit         = !r_used && (r_len >= size_q);
		status.rest_zero   = r_len == size_q;
		status.full        = cnt_q == CW'(MAX_SEGMENTS);
		status.match       = r_used && (r_start == where_q);
		status.next_exists = (idx_q + 1'b1) != cnt_q;
		status.k_zero      = k_d == 2'd0;
		status.dn_end      = dn_src >= {1'b0, cnt_q};
		status.up_end      = dst_q == idx_q;
		status.out_free    = !out_valid_q || out_ready;
	end

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = rdata_s1;
		case (cmd.op)
			DP_SCAN_RD: rd_en = !status.scan_end;
			DP_SCAN_CHK: begin
				if (status.is_free) begin
					rd_en   = status.match && status.next_exists;
					rd_addr = IW'(idx_q + 1'b1);
				end else if (status.fit && status.rest_zero) begin
					wr_en   = 1'b1;
					wr_data = {r_start, r_len, 1'b1};
				end
			end
			DP_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = p_d[IW-1:0];
				wr_data = {merge_start, merge_len, 1'b0};
			end
			DP_DN_RD: begin
				rd_en   = !status.dn_end;
				rd_addr = dn_src[IW-1:0];
			end
			DP_DN_WR: begin
				wr_en   = 1'b1;
				wr_addr = dst_q[IW-1:0];
			end
			DP_UP_RD: begin
				rd_en   = !status.up_end;
				rd_addr = IW'(dst_q - 1'b1);
			end
			DP_UP_WR: begin
				wr_en   = 1'b1;
				wr_addr = dst_q[IW-1:0];
			end
			DP_SPLIT1: begin
				wr_en   = 1'b1;
				wr_data = {start_q, size_q, 1'b1};
			end
			DP_SPLIT2: begin
				wr_en   = 1'b1;
				wr_addr = IW'(idx_q + 1'b1);
				wr_data = {start_q + size_q, rest_q, 1'b0};
			end
			DP_APPEND: begin
				wr_en   = (app_end <= XW'(limit_q)) && !status.full;
				wr_addr = cnt_q[IW-1:0];
				wr_data = {app_base[AW-1:0], size_q, 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q  <= ReservedSizeReset;
			limit_q     <= HeapLimitReset;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_RESERVED_SIZE) reserved_q <= cfg_wdata;
				else limit_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				DP_DN_RD:   if (status.dn_end) cnt_q <= cnt_q - CW'(k_q);
				DP_SPLIT2:  cnt_q <= cnt_q + 1'b1;
				DP_APPEND:  if (wr_en) cnt_q <= cnt_q + 1'b1;
				DP_FIN:     out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				cmd_q       <= in_cmd;
				size_q      <= in_size;
				where_q     <= in_where;
				idx_q       <= '0;
				prev_used_q <= 1'b1;
			end
			DP_SCAN_RD: begin
				if (status.scan_end) begin
					res_st_q   <= ST_NOT_FOUND;
					res_addr_q <= '0;
				end
			end
			DP_SCAN_CHK: begin
				if (status.is_free) begin
					if (status.match) begin
						cur_len_q  <= r_len;
						nxt_used_q <= 1'b1;
					end else begin
						prev_start_q <= r_start;
						prev_len_q   <= r_len;
						prev_used_q  <= r_used;
						idx_q        <= idx_q + 1'b1;
					end
				end else if (status.fit) begin
					if (status.rest_zero) begin
						res_st_q   <= ST_OK;
						res_addr_q <= r_start;
					end else if (status.full) begin
						res_st_q   <= ST_TABLE_FULL;
						res_addr_q <= '0;
					end else begin
						start_q <= r_start;
						rest_q  <= r_len - size_q;
						dst_q   <= cnt_q;
					end
				end else begin
					end_q <= XW'(r_start) + XW'(r_len);
					idx_q <= idx_q + 1'b1;
				end
			end
			DP_NXT: begin
				nxt_len_q  <= r_len;
				nxt_used_q <= r_used;
			end
			DP_MERGE: begin
				k_q        <= k_d;
				dst_q      <= p_d + 1'b1;
				res_st_q   <= ST_OK;
				res_addr_q <= where_q;
			end
			DP_DN_WR: dst_q <= dst_q + 1'b1;
			DP_UP_WR: dst_q <= dst_q - 1'b1;
			DP_SPLIT2: begin
				res_st_q   <= ST_OK;
				res_addr_q <= start_q;
			end
			DP_APPEND: begin
				if (app_end > XW'(limit_q)) begin
					res_st_q   <= ST_NO_SPACE;
					res_addr_q <= '0;
				end else if (status.full) begin
					res_st_q   <= ST_TABLE_FULL;
					res_addr_q <= '0;
				end else begin
					res_st_q   <= ST_OK;
					res_addr_q <= app_base[AW-1:0];
				end
			end
			DP_FIN: begin
				out_addr_q <= res_addr_q;
				out_st_q   <= res_st_q;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_status = out_st_q;

endmodule

@@ rtl/first_fit_allocator_unit.sv @@
`timescale 1ns / 1ps
// From request accept to result valid: a read and a check state per segment
// scanned, a read and a write state per entry moved when a split or merge
// shifts the table, then the finishing steps (append, split writes, merge
// write, output load); the output load waits while a result is still pending.
// One request at a time; the segment memory has a registered read.
// Reset: empty table, reserved_size 1, heap_limit 4096, no result pending.
// ---------------------------------------------------------------------------
// first_fit_allocator_unit
// First-fit heap allocator with coalescing over an ordered segment table.
// ---------------------------------------------------------------------------
module first_fit_allocator_unit
	import ffa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MaxSegmentsDefault,
	parameter int ADDR_WIDTH   = AddrWidthDefault
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// request_size, block_address
	input  logic [((2*ADDR_WIDTH+7)/8)*8-1:0]      s_tdata,
	// cmd
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// address, status
	output logic [((ADDR_WIDTH+2+7)/8)*8-1:0]      m_tdata,
	input  logic                                   cfg_wr_en,
	input  logic                                   cfg_index,
	input  logic [CfgWidth-1:0]                    cfg_wdata
);

	localparam int OW = ((ADDR_WIDTH + 2 + 7) / 8) * 8;

	ctrl_cmd_t             cmd;
	dp_status_t            status;
	logic [ADDR_WIDTH-1:0] out_addr;
	logic [1:0]            out_status;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ffa_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_cmd     (s_tuser),
		.in_size    (s_tdata[ADDR_WIDTH-1:0]),
		.in_where   (s_tdata[2*ADDR_WIDTH-1:ADDR_WIDTH]),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_addr   (out_addr),
		.out_status (out_status)
	);

	assign m_tdata = OW'({out_status, out_addr});

endmodule
